// File: src/strr_pkg.sv
`default_nettype none

package strr_pkg;

  // Tree geometry
  localparam int LEAVES     = 1024;
  localparam int LOG_LEAVES = $clog2(LEAVES);
  localparam int ADDR_W     = LOG_LEAVES + 1;   // heap node address, node 0 is the root
  localparam int NODE_DEPTH = 2 ** ADDR_W;
  localparam int POS_W      = LOG_LEAVES + 2;   // 1-based heap position, up to 2*LEAVES + slack

  // Field widths
  localparam int IDX_W     = 11;
  localparam int DATA_W    = 32;
  localparam int MOD_W     = 31;
  localparam int OP_W      = 2;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // Reset values of the configuration registers
  localparam logic [MOD_W-1:0]  MODULUS_RST   = MOD_W'(1000000007);
  localparam logic [IDX_W-1:0]  USED_SIZE_RST = IDX_W'(1024);

  typedef enum logic [OP_W-1:0] {
    OP_ADD,
    OP_ADD_MOD,
    OP_MAX,
    OP_MIN
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET,
    MODE_QUERY,
    MODE_REBUILD,
    MODE_NONE
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPERATION,
    CFG_MODULUS,
    CFG_USED_SIZE,
    CFG_FILL_VALUE
  } cfg_reg_t;

  typedef struct packed {
    op_t               operation;
    logic [MOD_W-1:0]  modulus;
    logic [IDX_W-1:0]  used_size;
    logic [DATA_W-1:0] fill_value;
  } cfg_t;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LOAD,
    DP_SET_LEAF,
    DP_SET_READ,
    DP_SET_UP,
    DP_Q_READ,
    DP_Q_ACC,
    DP_Q_FIN,
    DP_RB_LEAF,
    DP_RB_READ,
    DP_RB_WRITE,
    DP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic  clear_last;    // clearing pass writes its last node this cycle
    mode_t mode;          // mode of the loaded item
    logic  index_ok;      // loaded item passed its bounds check
    logic  pos_root;      // set walk has reached the root
    logic  q_more;        // query window still open (left < right)
    logic  rb_leaf_last;  // rebuild writes its last leaf this cycle
    logic  rb_node_last;  // rebuild handles the root this cycle
    logic  out_busy;      // output register holds a result that is not taken
  } dp_status_t;

endpackage

`default_nettype wire

// File: src/strr_ctrl.sv
`default_nettype none

module strr_ctrl
  import strr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  output dp_cmd_t         cmd,
  input  wire dp_status_t stat
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SET_LEAF,
    S_SET_READ,
    S_SET_UP,
    S_Q_READ,
    S_Q_ACC,
    S_RB_LEAF,
    S_RB_READ,
    S_RB_WRITE,
    S_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Take a new item only between items
  assign in_stall = (state_r != S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    case (state_r)
      S_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.mode)
          MODE_SET:     state_nxt = stat.index_ok ? S_SET_LEAF : S_RESULT;
          MODE_QUERY:   state_nxt = stat.index_ok ? S_Q_READ : S_RESULT;
          MODE_REBUILD: state_nxt = S_RB_LEAF;
          default:      state_nxt = S_RESULT;
        endcase
      end
      S_SET_LEAF: begin
        cmd.op    = DP_SET_LEAF;
        state_nxt = S_SET_READ;
      end
      S_SET_READ: begin
        if (stat.pos_root) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.op    = DP_SET_READ;
          state_nxt = S_SET_UP;
        end
      end
      S_SET_UP: begin
        cmd.op    = DP_SET_UP;
        state_nxt = S_SET_READ;
      end
      S_Q_READ: begin
        if (stat.q_more) begin
          cmd.op    = DP_Q_READ;
          state_nxt = S_Q_ACC;
        end else begin
          cmd.op    = DP_Q_FIN;
          state_nxt = S_RESULT;
        end
      end
      S_Q_ACC: begin
        cmd.op    = DP_Q_ACC;
        state_nxt = S_Q_READ;
      end
      S_RB_LEAF: begin
        cmd.op = DP_RB_LEAF;
        if (stat.rb_leaf_last) begin
          state_nxt = S_RB_READ;
        end
      end
      S_RB_READ: begin
        cmd.op    = DP_RB_READ;
        state_nxt = S_RB_WRITE;
      end
      S_RB_WRITE: begin
        cmd.op    = DP_RB_WRITE;
        state_nxt = stat.rb_node_last ? S_RESULT : S_RB_READ;
      end
      S_RESULT: begin
        if (!stat.out_busy) begin
          cmd.op    = DP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/strr_datapath.sv
`default_nettype none

module strr_datapath
  import strr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dp_cmd_t                  cmd,
  output dp_status_t                    stat,
  input  wire cfg_t                     cfg,
  input  wire logic [MODE_W-1:0]        in_mode,
  input  wire logic [IDX_W-1:0]         in_left_index,
  input  wire logic [IDX_W-1:0]         in_right_index,
  input  wire logic signed [DATA_W-1:0] in_write_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_reduced_value,
  output logic                          out_status
);

  localparam logic [POS_W-1:0] LEAVES_P = POS_W'(LEAVES);
  localparam logic [POS_W-1:0] ONE_P    = POS_W'(1);
  localparam logic [POS_W-1:0] TWO_P    = POS_W'(2);

  // Reduction operator: add-modulo subtracts the modulus from the sum once when the difference is not negative
  function automatic logic [DATA_W-1:0] combine(
    input op_t               op,
    input logic [MOD_W-1:0]  m,
    input logic [DATA_W-1:0] a,
    input logic [DATA_W-1:0] b
  );
    logic [DATA_W+1:0] s;
    logic [DATA_W+1:0] d;
    logic [DATA_W-1:0] r;
    s = {{2{a[DATA_W-1]}}, a} + {{2{b[DATA_W-1]}}, b};
    d = s - {{(DATA_W+2-MOD_W){1'b0}}, m};
    case (op)
      OP_ADD:     r = a + b;
      OP_ADD_MOD: r = d[DATA_W+1] ? s[DATA_W-1:0] : d[DATA_W-1:0];
      OP_MAX:     r = ($signed(a) >= $signed(b)) ? a : b;
      OP_MIN:     r = ($signed(a) <= $signed(b)) ? a : b;
      default:    r = a;
    endcase
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] identity_of(input op_t op);
    logic [DATA_W-1:0] r;
    case (op)
      OP_MAX:  r = INT_MIN;
      OP_MIN:  r = INT_MAX;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Node memory: one write port, two registered read ports
  logic [DATA_W-1:0] mem [NODE_DEPTH];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;

  // Item and walk registers
  mode_t             mode_r, mode_nxt;
  logic              err_r, err_nxt;
  logic [POS_W-1:0]  pos_l_r, pos_l_nxt;
  logic [POS_W-1:0]  pos_r_r, pos_r_nxt;
  logic [DATA_W-1:0] acc_l_r, acc_l_nxt;
  logic [DATA_W-1:0] acc_r_r, acc_r_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic              out_status_r, out_status_nxt;

  // Bounds check of the incoming item
  logic [POS_W-1:0]  li_p;
  logic [POS_W-1:0]  ri_p;
  logic              in_err;

  // Shared combine operands
  logic [DATA_W-1:0] ca_x;
  logic [DATA_W-1:0] ca_y;
  logic [DATA_W-1:0] comb_a;
  logic [DATA_W-1:0] comb_b;

  logic [LOG_LEAVES-1:0] leaf_idx;
  logic [DATA_W-1:0]     leaf_val;
  logic [POS_W:0]        child_l;

  assign li_p = POS_W'(in_left_index);
  assign ri_p = POS_W'(in_right_index);

  always_comb begin
    case (mode_t'(in_mode))
      MODE_SET:     in_err = !(li_p < LEAVES_P);
      MODE_QUERY:   in_err = !((li_p <= ri_p) && (ri_p <= LEAVES_P));
      MODE_REBUILD: in_err = 1'b0;
      default:      in_err = 1'b1;
    endcase
  end

  assign leaf_idx = cnt_r[LOG_LEAVES-1:0];
  assign leaf_val = ((IDX_W+1)'(leaf_idx) < (IDX_W+1)'(cfg.used_size)) ?
                    cfg.fill_value : identity_of(cfg.operation);
  assign child_l  = {cnt_r, 1'b0};

  // Pick combine operands, keeping left-to-right order
  always_comb begin
    ca_x = acc_l_r;
    ca_y = rd_a_r;
    case (cmd.op)
      DP_SET_UP: begin
        if (pos_l_r[0]) begin
          ca_x = rd_a_r;
          ca_y = acc_l_r;
        end
      end
      DP_Q_FIN: begin
        ca_y = acc_r_r;
      end
      DP_RB_WRITE: begin
        ca_x = rd_a_r;
        ca_y = rd_b_r;
      end
      default: begin
      end
    endcase
  end

  assign comb_a = combine(cfg.operation, cfg.modulus, ca_x, ca_y);
  assign comb_b = combine(cfg.operation, cfg.modulus, rd_b_r, acc_r_r);

  // Memory addressing
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    rd_addr_a = '0;
    rd_addr_b = '0;
    case (cmd.op)
      DP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[ADDR_W-1:0];
      end
      DP_SET_LEAF: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(pos_l_r - ONE_P);
        wr_data = acc_l_r;
      end
      DP_SET_READ: begin
        rd_addr_a = ADDR_W'((pos_l_r ^ ONE_P) - ONE_P);
      end
      DP_SET_UP: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'((pos_l_r >> 1) - ONE_P);
        wr_data = comb_a;
      end
      DP_Q_READ: begin
        rd_addr_a = ADDR_W'(pos_l_r - ONE_P);
        rd_addr_b = ADDR_W'(pos_r_r - TWO_P);
      end
      DP_RB_LEAF: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(cnt_r - ONE_P);
        wr_data = leaf_val;
      end
      DP_RB_READ: begin
        rd_addr_a = ADDR_W'(child_l - (POS_W+1)'(1));
        rd_addr_b = ADDR_W'(child_l);
      end
      DP_RB_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(cnt_r - ONE_P);
        wr_data = comb_a;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  // Register updates per command
  always_comb begin
    mode_nxt  = mode_r;
    err_nxt   = err_r;
    pos_l_nxt = pos_l_r;
    pos_r_nxt = pos_r_r;
    acc_l_nxt = acc_l_r;
    acc_r_nxt = acc_r_r;
    res_nxt   = res_r;
    cnt_nxt   = cnt_r;
    case (cmd.op)
      DP_CLEAR: begin
        cnt_nxt = cnt_r + ONE_P;
      end
      DP_LOAD: begin
        mode_nxt  = mode_t'(in_mode);
        err_nxt   = in_err;
        pos_l_nxt = li_p + LEAVES_P;
        pos_r_nxt = ri_p + LEAVES_P;
        acc_l_nxt = (mode_t'(in_mode) == MODE_SET) ? in_write_value :
                    identity_of(cfg.operation);
        acc_r_nxt = identity_of(cfg.operation);
        res_nxt   = '0;
        cnt_nxt   = LEAVES_P;
      end
      DP_SET_UP: begin
        acc_l_nxt = comb_a;
        pos_l_nxt = pos_l_r >> 1;
      end
      DP_Q_ACC: begin
        if (pos_l_r[0]) begin
          acc_l_nxt = comb_a;
        end
        if (pos_r_r[0]) begin
          acc_r_nxt = comb_b;
        end
        pos_l_nxt = (pos_l_r + POS_W'(pos_l_r[0])) >> 1;
        pos_r_nxt = pos_r_r >> 1;
      end
      DP_Q_FIN: begin
        res_nxt = comb_a;
      end
      DP_RB_LEAF: begin
        cnt_nxt = stat.rb_leaf_last ? (LEAVES_P - ONE_P) : (cnt_r + ONE_P);
      end
      DP_RB_WRITE: begin
        cnt_nxt = cnt_r - ONE_P;
      end
      default: begin
      end
    endcase
  end

  // Output register: load on result, drop on transfer
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    if (cmd.op == DP_RESULT) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = res_r;
      out_status_nxt = err_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    err_r        <= err_nxt;
    pos_l_r      <= pos_l_nxt;
    pos_r_r      <= pos_r_nxt;
    acc_l_r      <= acc_l_nxt;
    acc_r_r      <= acc_r_nxt;
    res_r        <= res_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // Status back to the controller
  always_comb begin
    stat.clear_last   = &cnt_r[ADDR_W-1:0];
    stat.mode         = mode_r;
    stat.index_ok     = !err_r;
    stat.pos_root     = (pos_l_r == ONE_P);
    stat.q_more       = (pos_l_r < pos_r_r);
    stat.rb_leaf_last = &leaf_idx;
    stat.rb_node_last = (cnt_r == ONE_P);
    stat.out_busy     = out_valid_r && out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_reduced_value = out_value_r;
  assign out_status        = out_status_r;

endmodule

`default_nettype wire

// File: src/segment_tree_range_reduce_core.sv
// One item at a time: a set walks up from the leaf to the root, a query walks both window edges up,
// a rebuild writes every leaf and then every inner node from the bottom up, and a rejected item goes
// straight to the result. A result waits while the output register holds one that is not taken;
// the next item is accepted once the result has entered the output register. Each tree level takes
// a read step and a combine step; the node memory has one write and two read ports. Reset (synchronous,
// rst_n low) loads register defaults and starts a pass zeroing every node; in_stall stays high till it ends.
`default_nettype none

module segment_tree_range_reduce_core
  import strr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [MODE_W-1:0]        in_mode,
  input  wire logic [IDX_W-1:0]         in_left_index,
  input  wire logic [IDX_W-1:0]         in_right_index,
  input  wire logic signed [DATA_W-1:0] in_write_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_reduced_value,
  output logic                          out_status,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_data
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  dp_cmd_t    cmd;
  dp_status_t stat;

  assign cfg_ready = 1'b1;

  // Register write on a configuration transfer
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_OPERATION:  cfg_nxt.operation  = op_t'(cfg_data[OP_W-1:0]);
        CFG_MODULUS:    cfg_nxt.modulus    = cfg_data[MOD_W-1:0];
        CFG_USED_SIZE:  cfg_nxt.used_size  = cfg_data[IDX_W-1:0];
        CFG_FILL_VALUE: cfg_nxt.fill_value = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.operation  <= OP_ADD;
      cfg_r.modulus    <= MODULUS_RST;
      cfg_r.used_size  <= USED_SIZE_RST;
      cfg_r.fill_value <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  strr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  strr_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg               (cfg_r),
    .in_mode           (in_mode),
    .in_left_index     (in_left_index),
    .in_right_index    (in_right_index),
    .in_write_value    (in_write_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_reduced_value (out_reduced_value),
    .out_status        (out_status)
  );

endmodule

`default_nettype wire

// File: sim/tb_segment_tree_range_reduce_core.sv
`timescale 1ns / 1ps

module tb_segment_tree_range_reduce_core;
  import strr_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASES        = 12;
  localparam int OPS_PER_PHASE = 150;
  localparam int HOLD_AT       = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    mode_t             mode;
    logic [IDX_W-1:0]  left;
    logic [IDX_W-1:0]  right;
    logic [DATA_W-1:0] value;
  } tree_op_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              status;
  } answer_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [MODE_W-1:0]        in_mode = '0;
  logic [IDX_W-1:0]         in_left_index = '0;
  logic [IDX_W-1:0]         in_right_index = '0;
  logic signed [DATA_W-1:0] in_write_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_reduced_value;
  logic                     out_status;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;

  segment_tree_range_reduce_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_left_index     (in_left_index),
    .in_right_index    (in_right_index),
    .in_write_value    (in_write_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_reduced_value (out_reduced_value),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the tree (1-based heap: leaf k at LEAVES+k) and its registers
  logic [DATA_W-1:0] shadow_tree [1:2*LEAVES-1];
  op_t               shadow_op;
  logic [MOD_W-1:0]  shadow_modulus;
  logic [IDX_W-1:0]  shadow_used;
  logic [DATA_W-1:0] shadow_init;

  tree_op_t    ops_to_send [$];
  answer_t     answers_due [$];
  int unsigned items_queued = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  bit          idling_on = 1'b1;

  function automatic logic [DATA_W-1:0] identity_value();
    case (shadow_op)
      OP_MAX:  return INT_MIN;
      OP_MIN:  return INT_MAX;
      default: return '0;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] reduce_pair(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    longint sa;
    longint sb;
    longint s;
    sa = $signed(a);
    sb = $signed(b);
    case (shadow_op)
      OP_ADD: return a + b;
      OP_ADD_MOD: begin
        // wide signed sum, one conditional subtract, keep the low word
        s = sa + sb;
        if (s >= longint'(shadow_modulus)) s = s - longint'(shadow_modulus);
        return DATA_W'(s);
      end
      OP_MAX:  return (sa >= sb) ? a : b;
      default: return (sa <= sb) ? a : b;
    endcase
  endfunction

  // Update the shadow tree for one op and return the answer it produces
  function automatic answer_t apply_tree_op(tree_op_t op);
    answer_t           ans;
    int                p;
    int                l;
    int                r;
    int                fill;
    logic [DATA_W-1:0] lacc;
    logic [DATA_W-1:0] racc;
    logic [DATA_W-1:0] idv;
    ans.value  = '0;
    ans.status = 1'b0;
    idv = identity_value();
    case (op.mode)
      MODE_SET: begin
        if (op.left < LEAVES) begin
          p = LEAVES + op.left;
          shadow_tree[p] = op.value;
          for (p = p / 2; p > 0; p = p / 2)
            shadow_tree[p] = reduce_pair(shadow_tree[2*p], shadow_tree[2*p+1]);
        end else begin
          ans.status = 1'b1;
        end
      end
      MODE_QUERY: begin
        if (op.left <= op.right && op.right <= LEAVES) begin
          lacc = idv;
          racc = idv;
          l = LEAVES + op.left;
          r = LEAVES + op.right;
          while (l < r) begin
            if (l % 2 == 1) begin
              lacc = reduce_pair(lacc, shadow_tree[l]);
              l++;
            end
            if (r % 2 == 1) begin
              r--;
              racc = reduce_pair(shadow_tree[r], racc);
            end
            l = l / 2;
            r = r / 2;
          end
          ans.value = reduce_pair(lacc, racc);
        end else begin
          ans.status = 1'b1;
        end
      end
      MODE_REBUILD: begin
        fill = (shadow_used > LEAVES) ? LEAVES : shadow_used;
        for (p = 0; p < LEAVES; p++)
          shadow_tree[LEAVES + p] = (p < fill) ? shadow_init : idv;
        for (p = LEAVES - 1; p > 0; p--)
          shadow_tree[p] = reduce_pair(shadow_tree[2*p], shadow_tree[2*p+1]);
      end
      default: ans.status = 1'b1;
    endcase
    return ans;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom();
    if (sel < 7) return DATA_W'($urandom_range(0, 200)) - 100;
    if (sel == 7 && shadow_modulus != 0) return $urandom_range(0, shadow_modulus - 1);
    case ($urandom_range(0, 3))
      0:       return INT_MIN;
      1:       return INT_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic queue_op(mode_t m, int unsigned l, int unsigned r, logic [DATA_W-1:0] v);
    tree_op_t op;
    op.mode  = m;
    op.left  = IDX_W'(l);
    op.right = IDX_W'(r);
    op.value = v;
    ops_to_send.push_back(op);
    items_queued++;
  endtask

  task automatic push_random_op();
    int unsigned sel;
    int unsigned l;
    int unsigned r;
    sel = $urandom_range(0, 99);
    l = $urandom_range(0, LEAVES);
    if (sel < 45) begin
      queue_op(MODE_SET, $urandom_range(0, LEAVES - 1), $urandom_range(0, 2047), pick_value());
    end else if (sel < 88) begin
      // mix short windows with wide ones
      if ($urandom_range(0, 1) == 1) begin
        r = l + $urandom_range(0, 16);
        if (r > LEAVES) r = LEAVES;
      end else begin
        r = $urandom_range(l, LEAVES);
      end
      queue_op(MODE_QUERY, l, r, $urandom());
    end else if (sel < 91) begin
      queue_op(MODE_SET, $urandom_range(LEAVES, 2047), $urandom_range(0, 2047), pick_value());
    end else if (sel < 94) begin
      queue_op(MODE_QUERY, $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom());
    end else if (sel < 98) begin
      queue_op(MODE_NONE, $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom());
    end else if (sel < 99) begin
      queue_op(MODE_QUERY, $urandom_range(LEAVES - 8, LEAVES), LEAVES, $urandom());
    end else begin
      queue_op(MODE_REBUILD, $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom());
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OPERATION:  shadow_op      = op_t'(data[OP_W-1:0]);
      CFG_MODULUS:    shadow_modulus = data[MOD_W-1:0];
      CFG_USED_SIZE:  shadow_used    = data[IDX_W-1:0];
      CFG_FILL_VALUE: shadow_init    = data;
      default: ;
    endcase
  endtask

  task automatic wait_for_answers();
    while (results_seen < items_queued) @(posedge clk);
  endtask

  function automatic void report_miss(string field, logic [DATA_W-1:0] want_v,
                                      logic [DATA_W-1:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s at result %0d: expected %h, got %h",
               field, results_seen, want_v, got_v);
  endfunction

  // Stimulus: reset, directed ops, then phases of register settings with random ops
  initial begin : stimulus
    int                ph;
    int                k;
    op_t               cfg_op;
    logic [MOD_W-1:0]  cfg_mod;
    logic [IDX_W-1:0]  cfg_used;
    logic [DATA_W-1:0] cfg_init;
    bit                with_rebuild;

    for (k = 1; k < 2*LEAVES; k++) shadow_tree[k] = '0;
    shadow_op      = OP_ADD;
    shadow_modulus = MODULUS_RST;
    shadow_used    = USED_SIZE_RST;
    shadow_init    = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: cleared tree, leaf extremes, bounds, empty windows, unused mode
    queue_op(MODE_QUERY, 0, LEAVES, '0);
    queue_op(MODE_SET, 0, 0, INT_MAX);
    queue_op(MODE_SET, LEAVES - 1, 0, INT_MIN);
    queue_op(MODE_SET, LEAVES, 0, 32'h1234_5678);
    queue_op(MODE_SET, 2047, 2047, '1);
    queue_op(MODE_QUERY, 0, LEAVES, '0);
    queue_op(MODE_QUERY, 0, 1, '0);
    queue_op(MODE_QUERY, LEAVES - 1, LEAVES, '0);
    queue_op(MODE_QUERY, 5, 5, '0);
    queue_op(MODE_QUERY, LEAVES, LEAVES, '0);
    queue_op(MODE_QUERY, 6, 5, '0);
    queue_op(MODE_QUERY, 0, LEAVES + 1, '0);
    queue_op(MODE_QUERY, 2047, 2047, '0);
    queue_op(MODE_QUERY, 0, 2047, '0);
    queue_op(MODE_NONE, 2047, 1234, '1);
    queue_op(MODE_SET, LEAVES / 2, 0, '1);
    queue_op(MODE_QUERY, LEAVES / 2 - 1, LEAVES / 2 + 1, '0);
    queue_op(MODE_REBUILD, 0, 0, '0);
    queue_op(MODE_QUERY, 0, LEAVES, '0);
    queue_op(MODE_SET, 7, 0, 32'd1234);
    queue_op(MODE_QUERY, 0, LEAVES, '0);

    for (ph = 0; ph < PHASES; ph++) begin
      // registers change only with the block drained
      wait_for_answers();
      idling_on = (ph != PHASES - 1);

      cfg_op       = op_t'($urandom_range(0, 3));
      cfg_mod      = ($urandom_range(0, 1) == 1) ? MOD_W'($urandom_range(1, 1000))
                                                 : MOD_W'($urandom());
      cfg_used     = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 2047))
                                                 : IDX_W'($urandom_range(1, LEAVES));
      cfg_init     = pick_value();
      with_rebuild = ($urandom_range(0, 3) != 0);
      case (ph)
        0: begin
          cfg_op = OP_ADD; cfg_used = IDX_W'(LEAVES); cfg_init = INT_MAX; with_rebuild = 1'b1;
        end
        1: begin
          cfg_op = OP_ADD_MOD; cfg_mod = {MOD_W{1'b1}}; cfg_used = IDX_W'(LEAVES);
          cfg_init = INT_MAX - 1; with_rebuild = 1'b1;
        end
        2: begin
          cfg_op = OP_ADD_MOD; cfg_mod = MOD_W'(1); cfg_used = '0; cfg_init = INT_MIN;
          with_rebuild = 1'b1;
        end
        3: begin
          cfg_op = OP_MAX; cfg_used = IDX_W'(1); cfg_init = INT_MIN; with_rebuild = 1'b1;
        end
        4: begin
          cfg_op = OP_MIN; cfg_used = IDX_W'(2047); cfg_init = INT_MAX; with_rebuild = 1'b1;
        end
        // switch operator over the existing min tree without a rebuild
        5: begin
          cfg_op = OP_MAX; with_rebuild = 1'b0;
        end
        // zero modulus turns add modulo into a plain add
        6: begin
          cfg_op = OP_ADD_MOD; cfg_mod = '0; with_rebuild = 1'b1;
        end
        7: begin
          cfg_op = OP_MIN; with_rebuild = 1'b1;
        end
        default: ;
      endcase

      write_reg(CFG_OPERATION, DATA_W'(cfg_op));
      write_reg(CFG_MODULUS, DATA_W'(cfg_mod));
      write_reg(CFG_USED_SIZE, DATA_W'(cfg_used));
      write_reg(CFG_FILL_VALUE, cfg_init);

      if (with_rebuild) queue_op(MODE_REBUILD, 0, 0, '0);
      queue_op(MODE_QUERY, 0, LEAVES, '0);
      queue_op(MODE_QUERY, LEAVES, LEAVES, '0);
      queue_op(MODE_QUERY, 0, 1, '0);
      queue_op(MODE_QUERY, LEAVES - 1, LEAVES, '0);
      repeat (OPS_PER_PHASE) push_random_op();
    end

    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (answers_due.size() != 0) mismatch_count += answers_due.size();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Input driver: offer queued ops, hold each until its transfer
  int unsigned send_gap = 0;
  tree_op_t    offered;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      // record the answer for the op taken at this edge
      if (in_valid && !in_stall) answers_due.push_back(apply_tree_op(offered));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (idling_on && $urandom_range(0, 99) < 20) begin
          send_gap = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else if (ops_to_send.size() > 0) begin
          offered = ops_to_send.pop_front();
          in_valid       <= 1'b1;
          in_mode        <= offered.mode;
          in_left_index  <= offered.left;
          in_right_index <= offered.right;
          in_write_value <= offered.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stall bursts plus one long hold-off
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned taken = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) taken++;
      if (!hold_done && taken == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 99) < 15) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker: compare each transfer with the oldest expected answer
  always @(posedge clk) begin : check_answers
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        report_miss("unexpected result", '0, out_reduced_value);
      end else begin
        want = answers_due.pop_front();
        if (out_reduced_value !== want.value)
          report_miss("reduced_value", want.value, out_reduced_value);
        if (out_status !== want.status)
          report_miss("status", DATA_W'(want.status), DATA_W'(out_status));
      end
    end
  end

  // Watchdog
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

// File: segment_tree_range_reduce_core.f
src/strr_pkg.sv
src/strr_ctrl.sv
src/strr_datapath.sv
src/segment_tree_range_reduce_core.sv
sim/tb_segment_tree_range_reduce_core.sv
